/* hdl/ssrs_pkg.sv */
// shared types and constants of the stepper start-ramp sequencer
`default_nettype none

package ssrs_pkg;

  // fixed widths of the channel fields
  localparam int unsigned NOW_W        = 32;
  localparam int unsigned COIL_W       = 4;
  localparam int unsigned DUTY_W       = 8;
  localparam int unsigned PERIOD_OUT_W = 20;
  localparam int unsigned PHASE_W      = 2;
  localparam int unsigned START_W      = 20;
  localparam int unsigned RAMP_W       = 16;
  localparam int unsigned PAT_W        = 16;
  localparam int unsigned CFG_IDX_W    = 2;
  localparam int unsigned CFG_DATA_W   = 20;

  // register indexes of the configuration port
  localparam logic [CFG_IDX_W-1:0] CFG_START_PERIOD  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_RAMP_INTERVAL = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_STEP_PATTERNS = 2'd2;

  // register reset values
  localparam logic [START_W-1:0] START_PERIOD_RST  = 20'd70000;
  localparam logic [RAMP_W-1:0]  RAMP_INTERVAL_RST = 16'd5000;
  localparam logic [PAT_W-1:0]   STEP_PATTERNS_RST = 16'd26985;

  // ramp band limits and the snap period
  localparam int unsigned BAND_FAST_LIMIT = 35000;
  localparam int unsigned BAND_MID_LIMIT  = 20000;
  localparam int unsigned BAND_SLOW_LIMIT = 10000;
  localparam int unsigned SNAP_PERIOD     = 7695;

  // period decrements per band
  localparam logic [4:0] DEC_FAST = 5'd30;
  localparam logic [4:0] DEC_MID  = 5'd15;
  localparam logic [4:0] DEC_SLOW = 5'd7;

  // pwm duty per band
  localparam logic [DUTY_W-1:0] DUTY_FAST = 8'd180;
  localparam logic [DUTY_W-1:0] DUTY_MID  = 8'd210;
  localparam logic [DUTY_W-1:0] DUTY_SLOW = 8'd220;
  localparam logic [DUTY_W-1:0] DUTY_RUN  = 8'd192;

  // configuration seen by the datapath
  typedef struct packed {
    logic               start_load;
    logic [START_W-1:0] start_value;
    logic [RAMP_W-1:0]  ramp_interval;
    logic [PAT_W-1:0]   step_patterns;
  } ssrs_cfg_t;

  // one result
  typedef struct packed {
    logic [COIL_W-1:0]       coil_drive;
    logic [DUTY_W-1:0]       pwm_duty;
    logic                    laser_enable;
    logic [PERIOD_OUT_W-1:0] period_us;
    logic [PHASE_W-1:0]      phase;
    logic                    commutated;
  } ssrs_result_t;

endpackage

`default_nettype wire

/* hdl/ssrs_channels.sv */
// request, result and configuration channel interfaces
`default_nettype none

interface ssrs_req_if
  import ssrs_pkg::*;
();
  logic             valid;
  logic             ready;
  logic [NOW_W-1:0] now_us;

  modport source (output valid, output now_us, input ready);
  modport sink   (input valid, input now_us, output ready);
endinterface

interface ssrs_res_if
  import ssrs_pkg::*;
();
  logic                    valid;
  logic                    ready;
  logic [COIL_W-1:0]       coil_drive;
  logic [DUTY_W-1:0]       pwm_duty;
  logic                    laser_enable;
  logic [PERIOD_OUT_W-1:0] period_us;
  logic [PHASE_W-1:0]      phase;
  logic                    commutated;

  modport source (output valid, output coil_drive, output pwm_duty, output laser_enable,
                  output period_us, output phase, output commutated, input ready);
  modport sink   (input valid, input coil_drive, input pwm_duty, input laser_enable,
                  input period_us, input phase, input commutated, output ready);
endinterface

interface ssrs_cfg_if
  import ssrs_pkg::*;
();
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

/* hdl/ssrs_cfg_regs.sv */
// configuration registers of the sequencer
`default_nettype none

module ssrs_cfg_regs
  import ssrs_pkg::*;
(
  input  wire logic   clk_i,
  input  wire logic   rst_ni,
  ssrs_cfg_if.sink    cfg_i,
  output ssrs_cfg_t   cfg_o
);

  logic [RAMP_W-1:0] ramp_interval_q, ramp_interval_d;
  logic [PAT_W-1:0]  step_patterns_q, step_patterns_d;
  logic              wr_en;

  // writes are always taken
  assign cfg_i.ready = 1'b1;
  assign wr_en       = cfg_i.valid;

  // register decode, unknown indexes ignored
  always_comb begin
    ramp_interval_d = ramp_interval_q;
    step_patterns_d = step_patterns_q;
    if (wr_en) begin
      case (cfg_i.index)
        CFG_RAMP_INTERVAL: ramp_interval_d = RAMP_W'(cfg_i.data);
        CFG_STEP_PATTERNS: step_patterns_d = PAT_W'(cfg_i.data);
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ramp_interval_q <= RAMP_INTERVAL_RST;
      step_patterns_q <= STEP_PATTERNS_RST;
    end else begin
      ramp_interval_q <= ramp_interval_d;
      step_patterns_q <= step_patterns_d;
    end
  end

  // start period goes straight into the period state
  assign cfg_o.start_load    = wr_en && (cfg_i.index == CFG_START_PERIOD);
  assign cfg_o.start_value   = START_W'(cfg_i.data);
  assign cfg_o.ramp_interval = ramp_interval_q;
  assign cfg_o.step_patterns = step_patterns_q;

endmodule

`default_nettype wire

/* hdl/ssrs_core.sv */
// ramp and commutation state with its single-pass update logic
`default_nettype none

module ssrs_core
  import ssrs_pkg::*;
#(
  parameter int unsigned TIME_BITS   = 32,
  parameter int unsigned PERIOD_BITS = 20
) (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire ssrs_cfg_t            cfg_i,
  input  wire logic                 step_i,
  input  wire logic [TIME_BITS-1:0] now_i,
  output ssrs_result_t              res_o
);

  localparam int unsigned SUM_W = (TIME_BITS > PERIOD_BITS) ? TIME_BITS : PERIOD_BITS;

  logic [PERIOD_BITS-1:0] period_q, period_d;
  logic [TIME_BITS-1:0]   ramp_last_q, ramp_last_d;
  logic [TIME_BITS-1:0]   commute_last_q, commute_last_d;
  logic [PHASE_W-1:0]     phase_q, phase_d;
  logic [COIL_W-1:0]      coil_q, coil_d;
  logic [DUTY_W-1:0]      duty_q, duty_d;
  logic                   laser_q, laser_d;

  logic                   band_fast, band_mid, band_slow, band_snap;
  logic [TIME_BITS-1:0]   ramp_limit, commute_limit;
  logic                   ramp_hit, commute_hit;
  logic [4:0]             dec;

  // band decode on the current period
  assign band_fast = period_q > PERIOD_BITS'(BAND_FAST_LIMIT);
  assign band_mid  = period_q > PERIOD_BITS'(BAND_MID_LIMIT);
  assign band_slow = period_q > PERIOD_BITS'(BAND_SLOW_LIMIT);
  assign band_snap = period_q > PERIOD_BITS'(SNAP_PERIOD);

  // ramp deadline, sum wraps at the time width
  assign ramp_limit = TIME_BITS'(SUM_W'(ramp_last_q) + SUM_W'(cfg_i.ramp_interval));
  assign ramp_hit   = now_i > ramp_limit;

  always_comb begin
    if (band_fast) begin
      dec = DEC_FAST;
    end else if (band_mid) begin
      dec = DEC_MID;
    end else begin
      dec = DEC_SLOW;
    end
  end

  // ramp update
  always_comb begin
    period_d    = period_q;
    ramp_last_d = ramp_last_q;
    duty_d      = duty_q;
    laser_d     = laser_q;
    if (band_slow) begin
      if (ramp_hit) begin
        ramp_last_d = now_i;
        period_d    = period_q - PERIOD_BITS'(dec);
      end
      if (band_fast) begin
        laser_d = 1'b1;
        duty_d  = DUTY_FAST;
      end else if (band_mid) begin
        duty_d = DUTY_MID;
      end else begin
        duty_d = DUTY_SLOW;
      end
    end else if (band_snap) begin
      laser_d  = 1'b0;
      duty_d   = DUTY_RUN;
      period_d = PERIOD_BITS'(SNAP_PERIOD);
    end
  end

  // commutation deadline uses the period after the ramp update
  assign commute_limit = TIME_BITS'(SUM_W'(commute_last_q) + SUM_W'(period_d));
  assign commute_hit   = now_i > commute_limit;

  always_comb begin
    commute_last_d = commute_last_q;
    coil_d         = coil_q;
    phase_d        = phase_q;
    if (commute_hit) begin
      commute_last_d = now_i;
      coil_d         = cfg_i.step_patterns[{phase_q, 2'b00} +: COIL_W];
      phase_d        = phase_q + PHASE_W'(1);
    end
  end

  // state registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      period_q       <= PERIOD_BITS'(START_PERIOD_RST);
      ramp_last_q    <= '0;
      commute_last_q <= '0;
      phase_q        <= '0;
      coil_q         <= '0;
      duty_q         <= DUTY_RUN;
      laser_q        <= 1'b0;
    end else if (cfg_i.start_load) begin
      period_q <= PERIOD_BITS'(cfg_i.start_value);
    end else if (step_i) begin
      period_q       <= period_d;
      ramp_last_q    <= ramp_last_d;
      commute_last_q <= commute_last_d;
      phase_q        <= phase_d;
      coil_q         <= coil_d;
      duty_q         <= duty_d;
      laser_q        <= laser_d;
    end
  end

  // result of the item in flight
  assign res_o.coil_drive   = coil_d;
  assign res_o.pwm_duty     = duty_d;
  assign res_o.laser_enable = laser_d;
  assign res_o.period_us    = PERIOD_OUT_W'(period_d);
  assign res_o.phase        = phase_d;
  assign res_o.commutated   = commute_hit;

`ifndef SYNTH
  // phase moves on by one at each commutation
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    step_i && !cfg_i.start_load && commute_hit |=> phase_q == $past(phase_q) + 2'd1)
    else $error("phase did not advance on commutation");

  // a step never raises the period
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    step_i && !cfg_i.start_load |=> period_q <= $past(period_q))
    else $error("period rose during a step");

  // commutation time stamp follows the item that commutated
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    step_i && !cfg_i.start_load && commute_hit |=> commute_last_q == $past(now_i))
    else $error("commutation time not captured");
`endif

endmodule

`default_nettype wire

/* hdl/stepper_start_ramp_sequencer_top.sv */
// Stepper start-ramp sequencer, top level.
// Requests on req_i carry a microsecond time stamp; each one yields exactly
// one result on res_o with the coil pattern, pwm duty, laser flag, period,
// next phase and a flag that tells whether the request commutated the coils.
// Configuration registers are written on cfg_i (index 0 start period, which
// also reloads the period, 1 ramp interval, 2 coil patterns); cfg_i is always
// ready, and the user must write it only while no request is in flight; the
// block itself does not enforce this. A request moves from the request register
// through the core into the result register. Throughput: one request per cycle
// while res_o.ready holds; the period and time stamps are updated by the
// combinational add and compare between the request and result registers.
// A stalled receiver holds the result register; one more request is parked in
// the request register and req_i.ready drops until the result is taken.
// Reset clears both valid flags, loads the period with 70000, duty 192, phase,
// coils, laser and time stamps zero, and restores the register defaults.
`default_nettype none

module stepper_start_ramp_sequencer_top
  import ssrs_pkg::*;
#(
  parameter int unsigned TIME_BITS   = 32,
  parameter int unsigned PERIOD_BITS = 20
) (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  ssrs_req_if.sink   req_i,
  ssrs_res_if.source res_o,
  ssrs_cfg_if.sink   cfg_i
);

  logic                 in_v_q;
  logic [TIME_BITS-1:0] now_q;
  logic                 out_v_q;
  ssrs_result_t         out_q;
  ssrs_result_t         core_res;
  ssrs_cfg_t            cfg;
  logic                 step;
  logic                 req_fire;

  ssrs_cfg_regs u_cfg_regs (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cfg_i  (cfg_i),
    .cfg_o  (cfg)
  );

  // the held request moves on when the result register is free or being emptied
  assign step        = in_v_q && (!out_v_q || res_o.ready);
  assign req_i.ready = !in_v_q || step;
  assign req_fire    = req_i.valid && req_i.ready;

  // request register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_v_q <= 1'b0;
    end else if (req_i.ready) begin
      in_v_q <= req_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_fire) begin
      now_q <= TIME_BITS'(req_i.now_us);
    end
  end

  ssrs_core #(
    .TIME_BITS   (TIME_BITS),
    .PERIOD_BITS (PERIOD_BITS)
  ) u_core (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cfg_i  (cfg),
    .step_i (step),
    .now_i  (now_q),
    .res_o  (core_res)
  );

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q <= 1'b0;
    end else if (step) begin
      out_v_q <= 1'b1;
    end else if (res_o.ready) begin
      out_v_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (step) begin
      out_q <= core_res;
    end
  end

  assign res_o.valid        = out_v_q;
  assign res_o.coil_drive   = out_q.coil_drive;
  assign res_o.pwm_duty     = out_q.pwm_duty;
  assign res_o.laser_enable = out_q.laser_enable;
  assign res_o.period_us    = out_q.period_us;
  assign res_o.phase        = out_q.phase;
  assign res_o.commutated   = out_q.commutated;

`ifndef SYNTH
  // a request parked behind a stalled result keeps its time stamp
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_v_q && out_v_q && !res_o.ready |=> in_v_q && $stable(now_q))
    else $error("parked request lost under stall");

  // a stalled result is never overwritten by a new step
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_v_q && !res_o.ready |-> !step)
    else $error("step while result stalled");

  // a step always leaves a result behind
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    step |=> out_v_q)
    else $error("result missing after step");
`endif

endmodule

`default_nettype wire
